[rtl/ibdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibdp_pkg
// Shared types, field slot codes and slot sizes of the indoor bike data parser.
// ----------------------------------------------------------------------------
package ibdp_pkg;

    localparam int NUM_SLOTS = 12;

    localparam logic [3:0] SLOT_SPEED      = 4'd0;
    localparam logic [3:0] SLOT_AVG_SPEED  = 4'd1;
    localparam logic [3:0] SLOT_CADENCE    = 4'd2;
    localparam logic [3:0] SLOT_AVG_CAD    = 4'd3;
    localparam logic [3:0] SLOT_DISTANCE   = 4'd4;
    localparam logic [3:0] SLOT_RESISTANCE = 4'd5;
    localparam logic [3:0] SLOT_POWER      = 4'd6;
    localparam logic [3:0] SLOT_AVG_POWER  = 4'd7;
    localparam logic [3:0] SLOT_ENERGY     = 4'd8;
    localparam logic [3:0] SLOT_HEART      = 4'd9;
    localparam logic [3:0] SLOT_MET        = 4'd10;
    localparam logic [3:0] SLOT_ELAPSED    = 4'd11;

    localparam logic [7:0] MIN_VALID_BYTES = 8'd4;

    typedef struct packed {
        logic        [15:0] speed_centi_kmh;
        logic        [14:0] cadence_rpm;
        logic        [23:0] distance_m;
        logic signed [15:0] resistance_level;
        logic signed [15:0] power_w;
        logic        [15:0] energy_kcal;
        logic        [7:0]  heart_rate_bpm;
        logic        [15:0] elapsed_s;
        logic               record_valid;
    } t_record;

    function automatic logic [2:0] slot_size(input logic [3:0] slot);
        logic [2:0] size;
        case (slot)
            SLOT_DISTANCE: size = 3'd3;
            SLOT_ENERGY:   size = 3'd5;
            SLOT_HEART:    size = 3'd1;
            SLOT_MET:      size = 3'd1;
            default:       size = 3'd2;
        endcase
        return size;
    endfunction

endpackage

[rtl/ibdp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibdp_parser
// Byte-at-a-time field walker: flag word, slot sequencing, field capture and
// record build on the last beat of a notification.
// ----------------------------------------------------------------------------
module ibdp_parser
    import ibdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_rec_valid,
    output t_record     o_rec
);

    logic [7:0]  r_count,   n_count;
    logic [15:0] r_flags,   n_flags;
    logic [3:0]  r_slot,    n_slot;
    logic [2:0]  r_pos,     n_pos;
    logic [23:0] r_accum,   n_accum;
    logic        r_stopped, n_stopped;
    t_record     r_vals,    n_vals;

    logic [23:0] v;
    logic [3:0]  nxt_slot;
    logic        nxt_found;

    always_comb begin
        n_count   = r_count;
        n_flags   = r_flags;
        n_slot    = r_slot;
        n_pos     = r_pos;
        n_accum   = r_accum;
        n_stopped = r_stopped;
        n_vals    = r_vals;
        v         = r_accum;
        nxt_slot  = r_slot;
        nxt_found = 1'b0;

        for (int t = NUM_SLOTS - 1; t >= 1; t--) begin
            if (r_flags[t] && (4'(t) > r_slot)) begin
                nxt_found = 1'b1;
                nxt_slot  = 4'(t);
            end
        end

        case (r_pos)
            3'd0:    v[7:0]   = r_accum[7:0]   | i_data_byte;
            3'd1:    v[15:8]  = r_accum[15:8]  | i_data_byte;
            3'd2:    v[23:16] = r_accum[23:16] | i_data_byte;
            default: v        = r_accum;
        endcase

        if (i_accept) begin
            if (r_count != 8'hFF) begin
                n_count = r_count + 8'd1;
            end
            if (r_count == 8'd0) begin
                n_flags[7:0] = i_data_byte;
            end else if (r_count == 8'd1) begin
                n_flags[15:8] = i_data_byte;
            end else if (!r_stopped) begin
                if (({1'b0, r_pos} + 4'd1) >= {1'b0, slot_size(r_slot)}) begin
                    case (r_slot)
                        SLOT_SPEED:      n_vals.speed_centi_kmh  = v[15:0];
                        SLOT_CADENCE:    n_vals.cadence_rpm      = v[15:1];
                        SLOT_DISTANCE:   n_vals.distance_m       = v;
                        SLOT_RESISTANCE: n_vals.resistance_level = v[15:0];
                        SLOT_POWER:      n_vals.power_w          = v[15:0];
                        SLOT_ENERGY:     n_vals.energy_kcal      = v[15:0];
                        SLOT_HEART:      n_vals.heart_rate_bpm   = v[7:0];
                        SLOT_ELAPSED:    n_vals.elapsed_s        = v[15:0];
                        default:         n_vals                  = r_vals;
                    endcase
                    if (nxt_found) begin
                        n_slot  = nxt_slot;
                        n_pos   = 3'd0;
                        n_accum = 24'd0;
                    end else begin
                        n_stopped = 1'b1;
                    end
                end else begin
                    n_accum = v;
                    n_pos   = r_pos + 3'd1;
                end
            end
        end
    end

    always_comb begin
        o_rec_valid = i_accept && i_last_byte;
        if (n_count >= MIN_VALID_BYTES) begin
            o_rec              = n_vals;
            o_rec.record_valid = 1'b1;
        end else begin
            o_rec = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_count   <= '0;
            r_flags   <= '0;
            r_slot    <= SLOT_SPEED;
            r_pos     <= '0;
            r_accum   <= '0;
            r_stopped <= 1'b0;
            r_vals    <= '0;
        end else begin
            r_count   <= n_count;
            r_flags   <= n_flags;
            r_slot    <= n_slot;
            r_pos     <= n_pos;
            r_accum   <= n_accum;
            r_stopped <= n_stopped;
            r_vals    <= n_vals;
        end
    end

endmodule

[rtl/ibdp_out_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibdp_out_skid
// Result register with one skid entry, so that a stalled record does not
// hold up the byte stream.
// ----------------------------------------------------------------------------
module ibdp_out_skid
    import ibdp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_record i_in_rec,
    output logic    o_full,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_record o_out_rec
);

    logic    r_main_valid, r_skid_valid;
    t_record r_main, r_skid;
    logic    main_free;

    assign main_free   = !r_main_valid || !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_out_rec   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= i_in_valid;
            end else begin
                r_main_valid <= i_in_valid;
            end
        end else if (i_in_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                r_skid <= i_in_rec;
            end else begin
                r_main <= i_in_rec;
            end
        end else if (i_in_valid) begin
            r_skid <= i_in_rec;
        end
    end

endmodule

[rtl/indoor_bike_data_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indoor_bike_data_parser_unit
// Indoor bike data notification parser: one payload byte per beat, one
// record per notification.
// ----------------------------------------------------------------------------
// The unit takes one byte every cycle while o_stall is low. Each byte updates
// the registered parser state; the record for a notification is built as its
// last byte is accepted and registered in the output register, or in its one
// skid entry while the output stalls, so the byte stream keeps flowing while a
// record waits; o_stall rises only when both hold a record behind a stall.
// ----------------------------------------------------------------------------
module indoor_bike_data_parser_unit
    import ibdp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_speed_centi_kmh,
    output logic [14:0]        o_cadence_rpm,
    output logic [23:0]        o_distance_m,
    output logic signed [15:0] o_resistance_level,
    output logic signed [15:0] o_power_w,
    output logic [15:0]        o_energy_kcal,
    output logic [7:0]         o_heart_rate_bpm,
    output logic [15:0]        o_elapsed_s,
    output logic               o_record_valid
);

    logic    accept;
    logic    rec_valid;
    logic    full;
    t_record rec;
    t_record out_rec;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    ibdp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    ibdp_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (rec_valid),
        .i_in_rec    (rec),
        .o_full      (full),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_out_rec   (out_rec)
    );

    assign o_speed_centi_kmh  = out_rec.speed_centi_kmh;
    assign o_cadence_rpm      = out_rec.cadence_rpm;
    assign o_distance_m       = out_rec.distance_m;
    assign o_resistance_level = out_rec.resistance_level;
    assign o_power_w          = out_rec.power_w;
    assign o_energy_kcal      = out_rec.energy_kcal;
    assign o_heart_rate_bpm   = out_rec.heart_rate_bpm;
    assign o_elapsed_s        = out_rec.elapsed_s;
    assign o_record_valid     = out_rec.record_valid;

endmodule
